// ===== src/m3i_pkg.sv =====
// m3i_pkg: shared widths, payload structs, lane index table and saturation helper
// for the 3x3 fixed-point matrix inverse; no dependencies
package m3i_pkg;

    localparam int EW  = 32;          // element width
    localparam int FW  = 16;          // fraction bits
    localparam int PW  = 2 * EW;      // product of two elements
    localparam int CW  = 2 * EW + 1;  // signed cofactor
    localparam int CMW = 2 * EW;      // cofactor magnitude
    localparam int DW  = 3 * EW + 2;  // signed determinant
    localparam int DMW = 3 * EW;      // determinant magnitude
    localparam int NW  = CMW + 2 * FW; // dividend magnitude
    localparam int XW  = DMW + EW + 1; // compare width in the divider
    localparam int NLANE = 9;

    typedef struct packed {
        logic signed [EW-1:0] a11;
        logic signed [EW-1:0] a12;
        logic signed [EW-1:0] a13;
        logic signed [EW-1:0] a21;
        logic signed [EW-1:0] a22;
        logic signed [EW-1:0] a23;
        logic signed [EW-1:0] a31;
        logic signed [EW-1:0] a32;
        logic signed [EW-1:0] a33;
    } t_mat;

    typedef struct packed {
        logic signed [EW-1:0] r11;
        logic signed [EW-1:0] r12;
        logic signed [EW-1:0] r13;
        logic signed [EW-1:0] r21;
        logic signed [EW-1:0] r22;
        logic signed [EW-1:0] r23;
        logic signed [EW-1:0] r31;
        logic signed [EW-1:0] r32;
        logic signed [EW-1:0] r33;
        logic                 singular;
    } t_res;

    // cofactor of lane n is e[a]*e[b] - e[c]*e[d], elements in row-major order
    localparam int unsigned COF_IDX [NLANE][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    // sign-magnitude to saturated two's complement
    function automatic logic [EW-1:0] sat_mag(input logic neg, input logic big,
                                              input logic [EW-1:0] mag);
        logic [EW-1:0] lim;
        lim = {1'b1, {(EW-1){1'b0}}};
        if (neg) begin
            sat_mag = (big || mag > lim) ? lim : (~mag + 1'b1);
        end else begin
            sat_mag = (big || mag > (lim - 1'b1)) ? (lim - 1'b1) : mag;
        end
    endfunction

endpackage

// ===== src/matrix3_inverse.sv =====
// matrix3_inverse: top level of the 3x3 fixed-point inverse (adjugate / determinant)
// depends on m3i_pkg, m3i_cof_lane, m3i_det, m3i_div_lane
//
// usage
//   - a transfer in happens at a rising edge with start high and busy low; busy
//     is always low, so a new matrix may be sent every cycle
//   - i_mat carries the nine signed Q16.16 elements, o_res the nine inverse
//     elements plus the singular flag
//   - each result sits on o_res for one cycle with o_done high; the receiver
//     must take it then, there is no way to stall the output
//   - a matrix passes the cofactor lanes, the determinant merge, the magnitude
//     and divider load registers, one divider stage per quotient bit in the
//     divider lanes, and the saturation register
//   - throughput is one matrix per clock, set by the fully pipelined divider
//     in each of the nine lanes
//   - a zero determinant returns the adjugate (cofactors shifted down by the
//     fraction bits) and sets singular
//   - reset clears the valid pipeline only; items in flight are dropped
module matrix3_inverse
    import m3i_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_mat i_mat,
    output t_res o_res,
    output logic o_done
);

    localparam int LAT = EW + 8;

    logic signed [EW-1:0] w_e [9];
    assign w_e = '{i_mat.a11, i_mat.a12, i_mat.a13, i_mat.a21, i_mat.a22,
                   i_mat.a23, i_mat.a31, i_mat.a32, i_mat.a33};

    // cofactor lanes
    logic signed [CW-1:0] w_cof [NLANE];
    for (genvar n = 0; n < NLANE; n++) begin : g_cof
        m3i_cof_lane u_cof (
            .i_clk (i_clk),
            .i_a   (w_e[COF_IDX[n][0]]),
            .i_b   (w_e[COF_IDX[n][1]]),
            .i_c   (w_e[COF_IDX[n][2]]),
            .i_d   (w_e[COF_IDX[n][3]]),
            .o_cof (w_cof[n])
        );
    end

    // first-column elements delayed to line up with the cofactors
    logic signed [EW-1:0] r_col_d1 [3];
    logic signed [EW-1:0] r_col_d2 [3];
    always_ff @(posedge i_clk) begin
        r_col_d1 <= '{w_e[0], w_e[3], w_e[6]};
        r_col_d2 <= r_col_d1;
    end

    // merge stage: determinant by expansion along the first column
    logic signed [DW-1:0] w_det;
    m3i_det u_det (
        .i_clk (i_clk),
        .i_e   (r_col_d2),
        .i_c   ('{w_cof[0], w_cof[1], w_cof[2]}),
        .o_det (w_det)
    );

    // cofactors wait for the determinant
    logic signed [CW-1:0] r_cof_d [3][NLANE];
    always_ff @(posedge i_clk) begin
        r_cof_d[0] <= w_cof;
        r_cof_d[1] <= r_cof_d[0];
        r_cof_d[2] <= r_cof_d[1];
    end

    // divider lanes
    logic [EW-1:0] w_res  [NLANE];
    logic          w_sing [NLANE];
    for (genvar n = 0; n < NLANE; n++) begin : g_div
        m3i_div_lane u_div (
            .i_clk  (i_clk),
            .i_cof  (r_cof_d[2][n]),
            .i_det  (w_det),
            .o_res  (w_res[n]),
            .o_sing (w_sing[n])
        );
    end

    // transfer tracking
    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] n_vld;
    assign n_vld = {r_vld[LAT-2:0], start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign busy   = 1'b0;
    assign o_done = r_vld[LAT-1];

    assign o_res.r11      = w_res[0];
    assign o_res.r12      = w_res[1];
    assign o_res.r13      = w_res[2];
    assign o_res.r21      = w_res[3];
    assign o_res.r22      = w_res[4];
    assign o_res.r23      = w_res[5];
    assign o_res.r31      = w_res[6];
    assign o_res.r32      = w_res[7];
    assign o_res.r33      = w_res[8];
    assign o_res.singular = w_sing[0];

`ifndef SYNTHESIS
    // every result comes from an earlier transfer on start
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LAT))
        else $error("result without matching transfer");

    // lanes 0, 4 and 8 agree on the singular decision
    a_sing_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (w_sing[0] == w_sing[4]) && (w_sing[0] == w_sing[8]))
        else $error("lanes disagree on singular");
`endif

endmodule

// ===== src/m3i_cof_lane.sv =====
// m3i_cof_lane: one cofactor a*b - c*d, two registered stages
// depends on m3i_pkg
module m3i_cof_lane
    import m3i_pkg::*;
(
    input  logic                 i_clk,
    input  logic signed [EW-1:0] i_a,
    input  logic signed [EW-1:0] i_b,
    input  logic signed [EW-1:0] i_c,
    input  logic signed [EW-1:0] i_d,
    output logic signed [CW-1:0] o_cof
);

    logic signed [PW-1:0] r_pab;
    logic signed [PW-1:0] r_pcd;
    logic signed [CW-1:0] r_cof;

    always_ff @(posedge i_clk) begin
        r_pab <= i_a * i_b;
        r_pcd <= i_c * i_d;
        r_cof <= CW'(r_pab) - CW'(r_pcd);
    end

    assign o_cof = r_cof;

endmodule

// ===== src/m3i_det.sv =====
// m3i_det: determinant from first-column elements and the first three cofactors
// split products, then recombine, then sum; depends on m3i_pkg
module m3i_det
    import m3i_pkg::*;
(
    input  logic                 i_clk,
    input  logic signed [EW-1:0] i_e [3],
    input  logic signed [CW-1:0] i_c [3],
    output logic signed [DW-1:0] o_det
);

    logic signed [2*EW:0]  r_lo [3];
    logic signed [2*EW:0]  r_hi [3];
    logic signed [DW-1:0]  r_t  [3];
    logic signed [DW-1:0]  r_det;

    for (genvar g = 0; g < 3; g++) begin : g_term
        always_ff @(posedge i_clk) begin
            r_lo[g] <= i_e[g] * $signed({1'b0, i_c[g][EW-1:0]});
            r_hi[g] <= i_e[g] * $signed(i_c[g][CW-1:EW]);
            r_t[g]  <= (DW'(r_hi[g]) <<< EW) + DW'(r_lo[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_det <= r_t[0] + r_t[1] + r_t[2];
    end

    assign o_det = r_det;

endmodule

// ===== src/m3i_div_lane.sv =====
// m3i_div_lane: cofactor / determinant, restoring divider one quotient bit a stage,
// singular select and saturation; depends on m3i_pkg
module m3i_div_lane
    import m3i_pkg::*;
(
    input  logic                 i_clk,
    input  logic signed [CW-1:0] i_cof,
    input  logic signed [DW-1:0] i_det,
    output logic        [EW-1:0] o_res,
    output logic                 o_sing
);

    // magnitudes
    logic           r_cneg, r_dneg, r_sing0;
    logic [CMW-1:0] r_cmag;
    logic [DMW-1:0] r_dmag0;

    always_ff @(posedge i_clk) begin
        r_cneg  <= i_cof[CW-1];
        r_dneg  <= i_det[DW-1];
        r_sing0 <= (i_det == '0);
        r_cmag  <= i_cof[CW-1] ? CMW'(-i_cof) : CMW'(i_cof);
        r_dmag0 <= i_det[DW-1] ? DMW'(-i_det) : DMW'(i_det);
    end

    // divider stages, index 0 is the loaded state
    logic [NW-1:0]  r_rem  [EW+1];
    logic [EW-1:0]  r_q    [EW+1];
    logic [DMW-1:0] r_dmag [EW+1];
    logic           r_neg  [EW+1];
    logic           r_ovf  [EW+1];
    logic           r_sing [EW+1];
    logic [EW-1:0]  r_sres [EW+1];

    logic [CMW-FW-1:0] w_sh;
    assign w_sh = r_cmag[CMW-1:FW];

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= NW'(r_cmag) << (2 * FW);
        r_q[0]    <= '0;
        r_dmag[0] <= r_dmag0;
        r_neg[0]  <= r_cneg ^ r_dneg;
        r_ovf[0]  <= (XW'(r_cmag) << (2 * FW)) >= (XW'(r_dmag0) << EW);
        r_sing[0] <= r_sing0;
        r_sres[0] <= sat_mag(r_cneg, |w_sh[CMW-FW-1:EW], w_sh[EW-1:0]);
    end

    for (genvar k = 0; k < EW; k++) begin : g_step
        localparam int SH = EW - 1 - k;
        logic [XW-1:0] w_div;
        logic          w_ge;
        assign w_div = XW'(r_dmag[k]) << SH;
        assign w_ge  = XW'(r_rem[k]) >= w_div;
        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= w_ge ? NW'(XW'(r_rem[k]) - w_div) : r_rem[k];
            r_q[k+1]    <= r_q[k] | (EW'(w_ge) << SH);
            r_dmag[k+1] <= r_dmag[k];
            r_neg[k+1]  <= r_neg[k];
            r_ovf[k+1]  <= r_ovf[k];
            r_sing[k+1] <= r_sing[k];
            r_sres[k+1] <= r_sres[k];
        end
    end

    logic [EW-1:0] r_res;
    logic          r_sout;

    always_ff @(posedge i_clk) begin
        r_res  <= r_sing[EW] ? r_sres[EW] : sat_mag(r_neg[EW], r_ovf[EW], r_q[EW]);
        r_sout <= r_sing[EW];
    end

    assign o_res  = r_res;
    assign o_sing = r_sout;

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for matrix3_inverse, random and corner 3x3 matrices
// depends on m3i_pkg and the matrix3_inverse rtl
`timescale 1ns / 100ps

module tb;
    import m3i_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_mat i_mat = '0;
    t_res o_res;
    logic o_done;

    matrix3_inverse DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_mat(i_mat), .o_res(o_res), .o_done(o_done)
    );

    always #10 i_clk = ~i_clk;

    t_mat mat_pending [$];
    t_res inv_expected [$];
    int   n_errors = 0;
    int   n_checked = 0;
    int   n_singular = 0;
    int   gap_left = 0;

    // draws a gap length: mostly zero, sometimes short, rarely long
    function automatic int draw_gap();
        int p;
        p = $urandom_range(99);
        if (p < 60) return 0;
        if (p < 95) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // exact adjugate over determinant, truncated toward zero then saturated; shifted adjugate when singular
    function automatic t_res inverse_of(t_mat m);
        logic signed [EW-1:0] e [9];
        logic signed [2*EW+1:0] adj [9];
        logic signed [3*EW+3:0] det;
        logic signed [4*EW+3:0] num, quo, lim_hi, lim_lo, val;
        logic [EW-1:0] out [9];
        bit sing;
        t_res r;
        e = '{m.a11, m.a12, m.a13, m.a21, m.a22, m.a23, m.a31, m.a32, m.a33};
        adj[0] = e[4]*e[8] - e[5]*e[7];
        adj[1] = e[2]*e[7] - e[1]*e[8];
        adj[2] = e[1]*e[5] - e[2]*e[4];
        adj[3] = e[5]*e[6] - e[3]*e[8];
        adj[4] = e[0]*e[8] - e[2]*e[6];
        adj[5] = e[2]*e[3] - e[0]*e[5];
        adj[6] = e[3]*e[7] - e[4]*e[6];
        adj[7] = e[1]*e[6] - e[0]*e[7];
        adj[8] = e[0]*e[4] - e[1]*e[3];
        det = e[0]*adj[0] + e[3]*adj[1] + e[6]*adj[2];
        sing = (det == 0);
        lim_hi = (1 <<< (EW-1)) - 1;
        lim_lo = -(1 <<< (EW-1));
        for (int i = 0; i < 9; i++) begin
            num = adj[i];
            if (sing) begin
                // arithmetic shift floors, so correct toward zero for negatives
                val = (num < 0) ? -((-num) >>> FW) : (num >>> FW);
            end else begin
                num = num <<< (2*FW);
                quo = num / det;   // sv signed division truncates toward zero
                val = quo;
            end
            if (val > lim_hi) val = lim_hi;
            if (val < lim_lo) val = lim_lo;
            out[i] = val[EW-1:0];
        end
        r = '{out[0], out[1], out[2], out[3], out[4], out[5], out[6], out[7], out[8],
              sing};
        return r;
    endfunction

    // element generator mixing extremes, small values and full-range noise
    function automatic logic [EW-1:0] rand_elem();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 0;
            3: return $urandom_range(3) << FW;
            4: return -($urandom_range(3) << FW);
            5: return $signed($urandom_range(1 << 18)) - (1 << 17);
            default: return $urandom();
        endcase
    endfunction

    function automatic t_mat rand_mat();
        t_mat m;
        m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
             rand_elem(), rand_elem(), rand_elem(), rand_elem()};
        // sometimes copy a row so the determinant is zero
        if ($urandom_range(9) == 0) begin
            m.a31 = m.a11; m.a32 = m.a12; m.a33 = m.a13;
        end
        return m;
    endfunction

    // driver: one transfer per cycle at most, random gaps between transfers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                inv_expected.push_back(inverse_of(i_mat));
            end
            if (start && busy) begin
                // hold the current item until taken
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (mat_pending.size() > 0) begin
                i_mat <= mat_pending.pop_front();
                start <= 1'b1;
                gap_left <= draw_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: results cannot be stalled, compare each one on arrival
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_done) begin
            if (inv_expected.size() == 0) begin
                $error("result transfer with no matrix outstanding");
                n_errors++;
            end else begin
                want = inv_expected.pop_front();
                n_checked++;
                if (want.singular) n_singular++;
                if (o_res.r11 !== want.r11) begin
                    $error("r11 expected %h got %h", want.r11, o_res.r11); n_errors++;
                end
                if (o_res.r12 !== want.r12) begin
                    $error("r12 expected %h got %h", want.r12, o_res.r12); n_errors++;
                end
                if (o_res.r13 !== want.r13) begin
                    $error("r13 expected %h got %h", want.r13, o_res.r13); n_errors++;
                end
                if (o_res.r21 !== want.r21) begin
                    $error("r21 expected %h got %h", want.r21, o_res.r21); n_errors++;
                end
                if (o_res.r22 !== want.r22) begin
                    $error("r22 expected %h got %h", want.r22, o_res.r22); n_errors++;
                end
                if (o_res.r23 !== want.r23) begin
                    $error("r23 expected %h got %h", want.r23, o_res.r23); n_errors++;
                end
                if (o_res.r31 !== want.r31) begin
                    $error("r31 expected %h got %h", want.r31, o_res.r31); n_errors++;
                end
                if (o_res.r32 !== want.r32) begin
                    $error("r32 expected %h got %h", want.r32, o_res.r32); n_errors++;
                end
                if (o_res.r33 !== want.r33) begin
                    $error("r33 expected %h got %h", want.r33, o_res.r33); n_errors++;
                end
                if (o_res.singular !== want.singular) begin
                    $error("singular expected %b got %b", want.singular, o_res.singular);
                    n_errors++;
                end
            end
        end
    end

    // stimulus: directed corners first, then random matrices
    initial begin
        t_mat m;
        logic [EW-1:0] one;
        one = 1 << FW;
        mat_pending.push_back({one, 32'h0, 32'h0, 32'h0, one, 32'h0, 32'h0, 32'h0, one});
        mat_pending.push_back('0);
        mat_pending.push_back({9{32'h7fff_ffff}});
        mat_pending.push_back({9{32'h8000_0000}});
        mat_pending.push_back({9{32'hffff_ffff}});
        mat_pending.push_back({32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h8000_0000,
                               32'h0, 32'h0, 32'h0, 32'h8000_0000});
        mat_pending.push_back({32'h7fff_ffff, 32'h0, 32'h0, 32'h0, 32'h8000_0000,
                               32'h0, 32'h0, 32'h0, 32'h7fff_ffff});
        // near singular: determinant of one lsb yields huge saturated quotients
        mat_pending.push_back({32'h1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0,
                               32'h0, 32'h1});
        mat_pending.push_back({32'h1, 32'h0, 32'h0, 32'h0, 32'hffff_ffff, 32'h0,
                               32'h0, 32'h0, 32'h1});
        // singular with nonzero adjugate, negative entries exercise truncation
        mat_pending.push_back({one, 32'h3, -one, 32'h5, 32'hffff_fff1, 32'h7,
                               one, 32'h3, -one});
        mat_pending.push_back({32'h2 << FW, 32'h0, 32'h0, 32'h0, -(32'h4 << FW),
                               32'h0, 32'h0, 32'h0, 32'h8 << FW});
        m = {32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678, 32'hedcb_a987, 32'h0f0f_0f0f,
             32'hf0f0_f0f0, 32'h0000_ffff, 32'hffff_0000, 32'h7fff_0001};
        mat_pending.push_back(m);
        mat_pending.push_back(~m);
        for (int i = 0; i < 1600; i++) mat_pending.push_back(rand_mat());

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (mat_pending.size() == 0);
        @(posedge i_clk);
        wait (!start);
        wait (inv_expected.size() == 0);
        repeat (EW + 20) @(posedge i_clk);
        $display("checked %0d inverses, %0d of them singular, extremes and random gaps",
                 n_checked, n_singular);
        if (n_errors == 0 && inv_expected.size() == 0) begin
            $display("PASS matrix3_inverse");
        end else begin
            $display("FAIL matrix3_inverse");
        end
        $finish;
    end

    // watchdog well beyond the slowest correct run
    initial begin
        #20ms;
        $display("FAIL matrix3_inverse");
        $finish;
    end

endmodule

// ===== files.f =====
src/m3i_pkg.sv
src/m3i_cof_lane.sv
src/m3i_det.sv
src/m3i_div_lane.sv
src/matrix3_inverse.sv
bench/tb.sv
